// File: src/tpps_pkg.sv
package tpps_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int ID_W     = 8;
    localparam int PERIOD_W = 24;
    localparam int PRIO_W   = 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index taken from paddr[2]
    localparam logic REG_PRIORITY_DESCENDING = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [PRIO_W-1:0]   prio;
    } task_rec_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wr_en;
        logic     swap_left;
        logic     swap_right;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } sorter_state_t;

endpackage

// File: src/tpps_cmp.sv
// True when record a must come strictly before record b.
module tpps_cmp (
    input  tpps_pkg::task_rec_t a,
    input  tpps_pkg::task_rec_t b,
    input  logic                desc,
    output logic                a_first
);

    always_comb
    begin
        if (a.period != b.period)
        begin
            a_first = (a.period < b.period);
        end
        else if (desc)
        begin
            a_first = (a.prio > b.prio);
        end
        else
        begin
            a_first = (a.prio < b.prio);
        end
    end

endmodule

// File: src/tpps_cell.sv
// One slot of the chain: load in place, swap with a neighbour, or shift towards the head.
module tpps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tpps_pkg::cell_ctrl_t ctrl,
    input  tpps_pkg::task_rec_t wr_rec,
    input  tpps_pkg::task_rec_t left_rec,
    input  tpps_pkg::task_rec_t right_rec,
    input  logic                right_vld,
    output tpps_pkg::task_rec_t rec,
    output logic                vld
);

    tpps_pkg::task_rec_t rec_reg;
    tpps_pkg::task_rec_t rec_next;
    logic                vld_reg;
    logic                vld_next;

    always_comb
    begin
        rec_next = rec_reg;
        vld_next = vld_reg;
        case (ctrl.op)
            tpps_pkg::CELL_LOAD:
            begin
                if (ctrl.wr_en)
                begin
                    rec_next = wr_rec;
                    vld_next = 1'b1;
                end
            end
            tpps_pkg::CELL_SORT:
            begin
                // swapping cells are both valid, so the valid bit holds
                if (ctrl.swap_left)
                begin
                    rec_next = left_rec;
                end
                else if (ctrl.swap_right)
                begin
                    rec_next = right_rec;
                end
            end
            tpps_pkg::CELL_SHIFT:
            begin
                rec_next = right_rec;
                vld_next = right_vld;
            end
            default:
            begin
                rec_next = rec_reg;
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign rec = rec_reg;
    assign vld = vld_reg;

endmodule

// File: src/task_period_priority_sorter_unit.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------------
// input    | in_valid / in_ready     | task_id, period_us, priority_req, last_task
// output   | out_valid / out_ready   | out_task_id, out_period_us, out_priority,
//          |                         | out_last, tasks_dropped
// config   | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Load one record a cycle into the next free cell, so records sit in arrival order;
// records that meet a full chain are dropped and flagged on tasks_dropped. The
// marked record starts an odd-even transposition sort; in_ready stays low from
// then until the last record has left the chain. Emit one record a cycle from the
// head while the output register is free or taken.
// Reset clears valid bits, count, drop flag, direction and the output valid flag.
module task_period_priority_sorter_unit #(
    parameter int MAX_TASKS = tpps_pkg::MAX_TASKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tpps_pkg::ID_W-1:0]           task_id,
    input  logic [tpps_pkg::PERIOD_W-1:0]       period_us,
    input  logic [tpps_pkg::PRIO_W-1:0]         priority_req,
    input  logic                                last_task,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tpps_pkg::ID_W-1:0]           out_task_id,
    output logic [tpps_pkg::PERIOD_W-1:0]       out_period_us,
    output logic [tpps_pkg::PRIO_W-1:0]         out_priority,
    output logic                                out_last,
    output logic                                tasks_dropped,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tpps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tpps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int PASS_W = $clog2(MAX_TASKS);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic prio_desc_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_desc_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr[2] == tpps_pkg::REG_PRIORITY_DESCENDING))
        begin
            prio_desc_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tpps_pkg::REG_PRIORITY_DESCENDING)
        begin
            prdata[0] = prio_desc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    tpps_pkg::sorter_state_t state_reg;
    tpps_pkg::sorter_state_t state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [PASS_W-1:0]       pass_reg;
    logic [PASS_W-1:0]       pass_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    desc_sort_reg;
    logic                    desc_sort_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tpps_pkg::task_rec_t     out_rec_reg;
    logic                    out_last_reg;
    logic                    out_drop_reg;
    logic                    out_load;

    // chain
    tpps_pkg::task_rec_t     cell_rec [MAX_TASKS];
    logic [MAX_TASKS-1:0]    cell_vld;
    logic [MAX_TASKS-2:0]    pair_swap;
    tpps_pkg::cell_op_t      chain_op;
    tpps_pkg::task_rec_t     in_rec;

    logic in_acc;
    logic chain_full;

    assign in_rec.id     = task_id;
    assign in_rec.period = period_us;
    assign in_rec.prio   = priority_req;

    assign in_ready   = (state_reg == tpps_pkg::ST_LOAD);
    assign in_acc     = in_valid & in_ready;
    assign chain_full = (count_reg == CNT_W'(MAX_TASKS));

    // Refill the output register when it is empty or being taken.
    assign out_load = (state_reg == tpps_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pass_next      = pass_reg;
        ovf_next       = ovf_reg;
        desc_sort_next = desc_sort_reg;
        out_valid_next = out_valid_reg && !out_ready;
        chain_op       = tpps_pkg::CELL_HOLD;
        case (state_reg)
            tpps_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    chain_op = tpps_pkg::CELL_LOAD;
                    if (chain_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_task)
                    begin
                        // sample the direction now for the whole set
                        desc_sort_next = prio_desc_reg;
                        pass_next      = PASS_W'(MAX_TASKS - 1);
                        state_next     = tpps_pkg::ST_SORT;
                    end
                end
            end
            tpps_pkg::ST_SORT:
            begin
                chain_op  = tpps_pkg::CELL_SORT;
                pass_next = pass_reg - PASS_W'(1);
                if (pass_reg == '0)
                begin
                    state_next = tpps_pkg::ST_EMIT;
                end
            end
            tpps_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    chain_op       = tpps_pkg::CELL_SHIFT;
                    out_valid_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        // set done: drop the flag, take the next set
                        ovf_next   = 1'b0;
                        state_next = tpps_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = tpps_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpps_pkg::ST_LOAD;
            count_reg     <= '0;
            pass_reg      <= '0;
            ovf_reg       <= 1'b0;
            desc_sort_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            ovf_reg       <= ovf_next;
            desc_sort_reg <= desc_sort_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rec_reg  <= cell_rec[0];
            out_last_reg <= (count_reg == CNT_W'(1));
            out_drop_reg <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_task_id   = out_rec_reg.id;
    assign out_period_us = out_rec_reg.period;
    assign out_priority  = out_rec_reg.prio;
    assign out_last      = out_last_reg;
    assign tasks_dropped = out_drop_reg;

    // ------------------------------------------------------------------
    // Compare-exchange between neighbours: even pairs on one cycle, odd
    // pairs on the next. Swap only on strict order to keep ties stable.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS - 1; gi++)
        begin : g_pair
            logic right_first;

            tpps_cmp u_cmp (
                .a       (cell_rec[gi+1]),
                .b       (cell_rec[gi]),
                .desc    (desc_sort_reg),
                .a_first (right_first)
            );

            assign pair_swap[gi] = (pass_reg[0] == 1'(gi % 2)) && cell_vld[gi]
                                   && cell_vld[gi+1] && right_first;
        end

        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            tpps_pkg::cell_ctrl_t ctrl;
            tpps_pkg::task_rec_t  left_rec;
            tpps_pkg::task_rec_t  right_rec;
            logic                 right_vld;

            assign ctrl.op    = chain_op;
            assign ctrl.wr_en = (count_reg == CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign ctrl.swap_left = 1'b0;
                assign left_rec       = '0;
            end
            else
            begin : g_body
                assign ctrl.swap_left = pair_swap[gi-1];
                assign left_rec       = cell_rec[gi-1];
            end

            if (gi == MAX_TASKS - 1)
            begin : g_tail
                assign ctrl.swap_right = 1'b0;
                assign right_rec       = '0;
                assign right_vld       = 1'b0;
            end
            else
            begin : g_inner
                assign ctrl.swap_right = pair_swap[gi];
                assign right_rec       = cell_rec[gi+1];
                assign right_vld       = cell_vld[gi+1];
            end

            tpps_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_rec    (in_rec),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .right_vld (right_vld),
                .rec       (cell_rec[gi]),
                .vld       (cell_vld[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Occupied cells always match the record count outside emission.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tpps_pkg::ST_EMIT) |-> ($countones(cell_vld) == count_reg))
        else $error("cell valid bits disagree with record count");

    // While records remain to be emitted, the head cell holds one.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpps_pkg::ST_EMIT && count_reg != '0) |-> cell_vld[0])
        else $error("head cell empty during emission");

    // A set that closes the emission leaves the chain empty.
    a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpps_pkg::ST_EMIT && out_load && count_reg == CNT_W'(1))
        |=> (cell_vld == '0 && count_reg == '0 && !ovf_reg))
        else $error("chain not empty after emission");

    // The sort never starts on an empty set.
    a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpps_pkg::ST_SORT) |-> (count_reg != '0))
        else $error("sort started with no records");

endmodule
